FILE: hdl/hsd_pkg.sv
package hsd_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_LEN_LONG = 2'd1;
  localparam logic [1:0] ST_BAD_PATH = 2'd2;

  localparam int TREE_NODES = 256;

  // Tree entry: [9] leaf, [8] no child, [7:0] octet or next node
  typedef logic [9:0] tree_ent_t;
  typedef tree_ent_t [TREE_NODES-1:0][1:0] tree_rom_t;

  localparam tree_ent_t ENT_NONE = 10'h100;

  // One result item
  typedef struct packed {
    logic [7:0] sym;
    logic       sym_valid;
    logic       str_end;
    logic [1:0] status;
  } res_t;

  // Static Huffman code, octets 0..255
  localparam int unsigned HCODE [256] = '{
    'h1ff8, 'h7fffd8, 'hfffffe2, 'hfffffe3, 'hfffffe4, 'hfffffe5, 'hfffffe6, 'hfffffe7,
    'hfffffe8, 'hffffea, 'h3ffffffc, 'hfffffe9, 'hfffffea, 'h3ffffffd, 'hfffffeb, 'hfffffec,
    'hfffffed, 'hfffffee, 'hfffffef, 'hffffff0, 'hffffff1, 'hffffff2, 'h3ffffffe, 'hffffff3,
    'hffffff4, 'hffffff5, 'hffffff6, 'hffffff7, 'hffffff8, 'hffffff9, 'hffffffa, 'hffffffb,
    'h14, 'h3f8, 'h3f9, 'hffa, 'h1ff9, 'h15, 'hf8, 'h7fa,
    'h3fa, 'h3fb, 'hf9, 'h7fb, 'hfa, 'h16, 'h17, 'h18,
    'h0, 'h1, 'h2, 'h19, 'h1a, 'h1b, 'h1c, 'h1d,
    'h1e, 'h1f, 'h5c, 'hfb, 'h7ffc, 'h20, 'hffb, 'h3fc,
    'h1ffa, 'h21, 'h5d, 'h5e, 'h5f, 'h60, 'h61, 'h62,
    'h63, 'h64, 'h65, 'h66, 'h67, 'h68, 'h69, 'h6a,
    'h6b, 'h6c, 'h6d, 'h6e, 'h6f, 'h70, 'h71, 'h72,
    'hfc, 'h73, 'hfd, 'h1ffb, 'h7fff0, 'h1ffc, 'h3ffc, 'h22,
    'h7ffd, 'h3, 'h23, 'h4, 'h24, 'h5, 'h25, 'h26,
    'h27, 'h6, 'h74, 'h75, 'h28, 'h29, 'h2a, 'h7,
    'h2b, 'h76, 'h2c, 'h8, 'h9, 'h2d, 'h77, 'h78,
    'h79, 'h7a, 'h7b, 'h7ffe, 'h7fc, 'h3ffd, 'h1ffd, 'hffffffc,
    'hfffe6, 'h3fffd2, 'hfffe7, 'hfffe8, 'h3fffd3, 'h3fffd4, 'h3fffd5, 'h7fffd9,
    'h3fffd6, 'h7fffda, 'h7fffdb, 'h7fffdc, 'h7fffdd, 'h7fffde, 'hffffeb, 'h7fffdf,
    'hffffec, 'hffffed, 'h3fffd7, 'h7fffe0, 'hffffee, 'h7fffe1, 'h7fffe2, 'h7fffe3,
    'h7fffe4, 'h1fffdc, 'h3fffd8, 'h7fffe5, 'h3fffd9, 'h7fffe6, 'h7fffe7, 'hffffef,
    'h3fffda, 'h1fffdd, 'hfffe9, 'h3fffdb, 'h3fffdc, 'h7fffe8, 'h7fffe9, 'h1fffde,
    'h7fffea, 'h3fffdd, 'h3fffde, 'hfffff0, 'h1fffdf, 'h3fffdf, 'h7fffeb, 'h7fffec,
    'h1fffe0, 'h1fffe1, 'h3fffe0, 'h1fffe2, 'h7fffed, 'h3fffe1, 'h7fffee, 'h7fffef,
    'hfffea, 'h3fffe2, 'h3fffe3, 'h3fffe4, 'h7ffff0, 'h3fffe5, 'h3fffe6, 'h7ffff1,
    'h3ffffe0, 'h3ffffe1, 'hfffeb, 'h7fff1, 'h3fffe7, 'h7ffff2, 'h3fffe8, 'h1ffffec,
    'h3ffffe2, 'h3ffffe3, 'h3ffffe4, 'h7ffffde, 'h7ffffdf, 'h3ffffe5, 'hfffff1, 'h1ffffed,
    'h7fff2, 'h1fffe3, 'h3ffffe6, 'h7ffffe0, 'h7ffffe1, 'h3ffffe7, 'h7ffffe2, 'hfffff2,
    'h1fffe4, 'h1fffe5, 'h3ffffe8, 'h3ffffe9, 'hffffffd, 'h7ffffe3, 'h7ffffe4, 'h7ffffe5,
    'hfffec, 'hfffff3, 'hfffed, 'h1fffe6, 'h3fffe9, 'h1fffe7, 'h1fffe8, 'h7ffff3,
    'h3fffea, 'h3fffeb, 'h1ffffee, 'h1ffffef, 'hfffff4, 'hfffff5, 'h3ffffea, 'h7ffff4,
    'h3ffffeb, 'h7ffffe6, 'h3ffffec, 'h3ffffed, 'h7ffffe7, 'h7ffffe8, 'h7ffffe9, 'h7ffffea,
    'h7ffffeb, 'hffffffe, 'h7ffffec, 'h7ffffed, 'h7ffffee, 'h7ffffef, 'h7fffff0, 'h3ffffee
  };

  localparam int HLEN [256] = '{
    13, 23, 28, 28, 28, 28, 28, 28, 28, 24, 30, 28, 28, 30, 28, 28,
    28, 28, 28, 28, 28, 28, 30, 28, 28, 28, 28, 28, 28, 28, 28, 28,
    6, 10, 10, 12, 13, 6, 8, 11, 10, 10, 8, 11, 8, 6, 6, 6,
    5, 5, 5, 6, 6, 6, 6, 6, 6, 6, 7, 8, 15, 6, 12, 10,
    13, 6, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7,
    7, 7, 7, 7, 7, 7, 7, 7, 8, 7, 8, 13, 19, 13, 14, 6,
    15, 5, 6, 5, 6, 5, 6, 6, 6, 5, 7, 7, 6, 6, 6, 5,
    6, 7, 6, 5, 5, 6, 7, 7, 7, 7, 7, 15, 11, 14, 13, 28,
    20, 22, 20, 20, 22, 22, 22, 23, 22, 23, 23, 23, 23, 23, 24, 23,
    24, 24, 22, 23, 24, 23, 23, 23, 23, 21, 22, 23, 22, 23, 23, 24,
    22, 21, 20, 22, 22, 23, 23, 21, 23, 22, 22, 24, 21, 22, 23, 23,
    21, 21, 22, 21, 23, 22, 23, 23, 20, 22, 22, 22, 23, 22, 22, 23,
    26, 26, 20, 19, 22, 23, 22, 25, 26, 26, 26, 27, 27, 26, 24, 25,
    19, 21, 26, 27, 27, 26, 27, 24, 21, 21, 26, 26, 28, 27, 27, 27,
    20, 24, 20, 21, 22, 21, 21, 23, 22, 22, 25, 25, 24, 24, 26, 23,
    26, 27, 26, 26, 27, 27, 27, 27, 27, 28, 27, 27, 27, 27, 27, 26
  };

  // Build the code tree at elaboration: two children per internal node
  function automatic tree_rom_t build_code_rom();
    tree_rom_t t;
    int        nxt;
    int        node;
    bit        ok;
    tree_ent_t v;
    int        b;
    for (int n = 0; n < TREE_NODES; n++) begin
      t[n][0] = ENT_NONE;
      t[n][1] = ENT_NONE;
    end
    nxt = 1;
    for (int s = 0; s < 256; s++) begin
      node = 0;
      ok = 1'b1;
      for (int i = HLEN[s] - 1; i >= 1; i--) begin
        if (ok) begin
          b = int'((HCODE[s] >> i) & 1);
          v = t[node][b];
          if (v[8]) begin
            if (nxt >= TREE_NODES) begin
              ok = 1'b0;
            end else begin
              v = {2'b00, 8'(nxt)};
              nxt++;
              t[node][b] = v;
            end
          end else if (v[9]) begin
            ok = 1'b0;
          end
          if (ok) node = int'(v[7:0]);
        end
      end
      if (ok) t[node][HCODE[s] & 1] = {2'b10, 8'(s)};
    end
    return t;
  endfunction

endpackage

FILE: hdl/hpack_string_decoder_core.sv
// HPACK string literal decoder.
// Input channel: one byte of the header block per request (in_byte), with
// in_begin_string marking the first byte of a literal. Output channel: one
// result per request (symbol, symbol_valid, string_end, status); a byte
// gives zero, one or two results.
// Length and raw payload bytes are handled by the controller in S_IDLE; any
// result they give is staged through S_EMIT. A Huffman payload byte is shifted
// through the code tree one bit per cycle while no result waits in S_EMIT, and
// the input stays stalled until each result is handed to the output register
// and S_FIN closes the byte. The tree walk does one ROM lookup per bit.
// The last decoded symbol is held back until the byte closes so that it can
// carry string_end.
// A single output register sits between the controller and the receiver;
// while the receiver stalls and that register is full, a result staged in
// S_EMIT waits and in_stall stays high.
// Synchronous reset clears the controller to idle with no result pending.
module hpack_string_decoder_core #(
  parameter int LENGTH_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_begin_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_symbol,
  output logic       out_symbol_valid,
  output logic       out_string_end,
  output logic [1:0] out_status
);

  localparam hsd_pkg::tree_rom_t TREE = hsd_pkg::build_code_rom();

  typedef enum logic [2:0] {S_IDLE, S_WALK, S_FIN, S_EMIT, S_ERR} state_t;
  typedef enum logic [1:0] {P_IDLE, P_LENGTH, P_PAYLOAD} phase_t;

  state_t                 st_r, st_nxt, ret_r, ret_nxt;
  phase_t                 phase_r, phase_nxt;
  logic                   huff_r, huff_nxt;
  logic [LENGTH_BITS-1:0] acc_r, acc_nxt;
  logic [4:0]             shamt_r, shamt_nxt;
  logic [LENGTH_BITS-1:0] left_r, left_nxt;
  logic [7:0]             pos_r, pos_nxt;
  logic [7:0]             sh_r, sh_nxt;
  logic [2:0]             cnt_r, cnt_nxt;
  logic                   last_r, last_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [7:0]             pend_r, pend_nxt;
  hsd_pkg::res_t          res_r, res_nxt;
  hsd_pkg::res_t          out_r, out_nxt;
  logic                   out_v_r, out_v_nxt;

  logic                   acc_in;
  logic                   slot_free;
  logic [34:0]            add_term;
  logic [LENGTH_BITS-1:0] acc_sum;
  logic [5:0]             sh_next;
  hsd_pkg::tree_ent_t     ent;

  assign in_stall  = (st_r != S_IDLE);
  assign acc_in    = in_valid && !in_stall;
  assign slot_free = !out_v_r || !out_stall;

  // Length accumulation with the shift capped at 28
  assign add_term = {28'd0, in_byte[6:0]} << shamt_r;
  assign acc_sum  = acc_r + add_term[LENGTH_BITS-1:0];
  assign sh_next  = {1'b0, shamt_r} + 6'd7;

  assign ent = TREE[pos_r][sh_r[7]];

  always_comb begin
    st_nxt     = st_r;
    ret_nxt    = ret_r;
    phase_nxt  = phase_r;
    huff_nxt   = huff_r;
    acc_nxt    = acc_r;
    shamt_nxt  = shamt_r;
    left_nxt   = left_r;
    pos_nxt    = pos_r;
    sh_nxt     = sh_r;
    cnt_nxt    = cnt_r;
    last_nxt   = last_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    res_nxt    = res_r;
    out_nxt    = out_r;
    out_v_nxt  = out_v_r && out_stall;

    case (st_r)
      S_IDLE: begin
        if (acc_in) begin
          if (in_begin_string) begin
            // Start a literal: flag and length prefix
            huff_nxt  = in_byte[7];
            pos_nxt   = '0;
            shamt_nxt = '0;
            if (in_byte[6:0] != 7'h7f) begin
              acc_nxt  = LENGTH_BITS'(in_byte[6:0]);
              left_nxt = LENGTH_BITS'(in_byte[6:0]);
              if (in_byte[6:0] == 7'd0) begin
                phase_nxt = P_IDLE;
                res_nxt   = '{8'd0, 1'b0, 1'b1, hsd_pkg::ST_OK};
                ret_nxt   = S_IDLE;
                st_nxt    = S_EMIT;
              end else begin
                phase_nxt = P_PAYLOAD;
              end
            end else begin
              acc_nxt   = LENGTH_BITS'(7'h7f);
              phase_nxt = P_LENGTH;
            end
          end else if (phase_r == P_LENGTH) begin
            // Continuation byte of the length
            acc_nxt = acc_sum;
            if (!in_byte[7]) begin
              left_nxt = acc_sum;
              pos_nxt  = '0;
              if (acc_sum == '0) begin
                phase_nxt = P_IDLE;
                res_nxt   = '{8'd0, 1'b0, 1'b1, hsd_pkg::ST_OK};
                ret_nxt   = S_IDLE;
                st_nxt    = S_EMIT;
              end else begin
                phase_nxt = P_PAYLOAD;
              end
            end else if (sh_next > 6'd28) begin
              shamt_nxt = 5'd28;
              phase_nxt = P_IDLE;
              res_nxt   = '{8'd0, 1'b0, 1'b1, hsd_pkg::ST_LEN_LONG};
              ret_nxt   = S_IDLE;
              st_nxt    = S_EMIT;
            end else begin
              shamt_nxt = sh_next[4:0];
            end
          end else if (phase_r == P_PAYLOAD && left_r != '0) begin
            // Payload byte
            left_nxt = left_r - LENGTH_BITS'(1);
            last_nxt = (left_r == LENGTH_BITS'(1));
            if (left_r == LENGTH_BITS'(1)) phase_nxt = P_IDLE;
            if (!huff_r) begin
              res_nxt = '{in_byte, 1'b1, left_r == LENGTH_BITS'(1), hsd_pkg::ST_OK};
              ret_nxt = S_IDLE;
              st_nxt  = S_EMIT;
            end else begin
              sh_nxt  = in_byte;
              cnt_nxt = 3'd7;
              st_nxt  = S_WALK;
            end
          end
        end
      end

      S_WALK: begin
        // Advance one bit through the code tree
        sh_nxt  = {sh_r[6:0], 1'b0};
        cnt_nxt = cnt_r - 3'd1;
        if (ent[8]) begin
          phase_nxt = P_IDLE;
          pos_nxt   = '0;
          if (pend_v_r) begin
            res_nxt    = '{pend_r, 1'b1, 1'b0, hsd_pkg::ST_OK};
            pend_v_nxt = 1'b0;
            ret_nxt    = S_ERR;
          end else begin
            res_nxt = '{8'd0, 1'b0, 1'b1, hsd_pkg::ST_BAD_PATH};
            ret_nxt = S_IDLE;
          end
          st_nxt = S_EMIT;
        end else if (ent[9]) begin
          pos_nxt    = '0;
          pend_v_nxt = 1'b1;
          pend_nxt   = ent[7:0];
          if (pend_v_r) begin
            res_nxt = '{pend_r, 1'b1, 1'b0, hsd_pkg::ST_OK};
            ret_nxt = (cnt_r == 3'd0) ? S_FIN : S_WALK;
            st_nxt  = S_EMIT;
          end else if (cnt_r == 3'd0) begin
            st_nxt = S_FIN;
          end
        end else begin
          pos_nxt = ent[7:0];
          if (cnt_r == 3'd0) st_nxt = S_FIN;
        end
      end

      S_FIN: begin
        // Close the byte: flush the held symbol and, on the last byte, mark the string end
        pend_v_nxt = 1'b0;
        ret_nxt    = S_IDLE;
        if (last_r) begin
          pos_nxt = '0;
          if (pend_v_r) begin
            res_nxt = '{pend_r, 1'b1, 1'b1, hsd_pkg::ST_OK};
          end else begin
            res_nxt = '{8'd0, 1'b0, 1'b1, hsd_pkg::ST_OK};
          end
          st_nxt  = S_EMIT;
        end else if (pend_v_r) begin
          res_nxt = '{pend_r, 1'b1, 1'b0, hsd_pkg::ST_OK};
          st_nxt  = S_EMIT;
        end else begin
          st_nxt = S_IDLE;
        end
      end

      S_ERR: begin
        res_nxt = '{8'd0, 1'b0, 1'b1, hsd_pkg::ST_BAD_PATH};
        ret_nxt = S_IDLE;
        st_nxt  = S_EMIT;
      end

      S_EMIT: begin
        // Hand the staged result to the output register
        if (slot_free) begin
          out_nxt   = res_r;
          out_v_nxt = 1'b1;
          st_nxt    = ret_r;
        end
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  // Hold state, payload and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      ret_r    <= S_IDLE;
      phase_r  <= P_IDLE;
      huff_r   <= 1'b0;
      acc_r    <= '0;
      shamt_r  <= '0;
      left_r   <= '0;
      pos_r    <= '0;
      cnt_r    <= '0;
      last_r   <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      sh_r     <= '0;
      pend_r   <= '0;
      res_r    <= '0;
      out_r    <= '0;
    end else begin
      st_r     <= st_nxt;
      ret_r    <= ret_nxt;
      phase_r  <= phase_nxt;
      huff_r   <= huff_nxt;
      acc_r    <= acc_nxt;
      shamt_r  <= shamt_nxt;
      left_r   <= left_nxt;
      pos_r    <= pos_nxt;
      cnt_r    <= cnt_nxt;
      last_r   <= last_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      sh_r     <= sh_nxt;
      pend_r   <= pend_nxt;
      res_r    <= res_nxt;
      out_r    <= out_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign out_symbol       = out_r.sym;
  assign out_symbol_valid = out_r.sym_valid;
  assign out_string_end   = out_r.str_end;
  assign out_status       = out_r.status;

endmodule

FILE: hdl/hsd_checker.sv
module hsd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_symbol,
  input logic       out_symbol_valid,
  input logic       out_string_end,
  input logic [1:0] out_status
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_symbol) &&
      $stable(out_string_end) && $stable(out_status))
    else $error("stalled result changed");

  // An error result closes the string and carries no octet
  a_err_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != hsd_pkg::ST_OK |-> out_string_end && !out_symbol_valid)
    else $error("error result not closing string");

  // Status codes stay in range
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == hsd_pkg::ST_OK || out_status == hsd_pkg::ST_LEN_LONG ||
      out_status == hsd_pkg::ST_BAD_PATH))
    else $error("bad status code");

  // A decoded octet never reports an error
  a_sym_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_symbol_valid |-> out_status == hsd_pkg::ST_OK)
    else $error("symbol with error status");

  // An idle block with no request stays ready
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall && !in_valid |=> !in_stall)
    else $error("stall raised without a request");

endmodule

bind hpack_string_decoder_core hsd_checker u_hsd_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_symbol(out_symbol),
  .out_symbol_valid(out_symbol_valid), .out_string_end(out_string_end),
  .out_status(out_status)
);
